/* hw/rtl/pli_pkg.sv */
// Shared types, status codes and defaults for the piecewise linear interpolator.
package pli_pkg;

   localparam int MAX_POINTS_DEFAULT = 16;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_UNSORTED = 2'd1;
   localparam logic [1:0] STAT_RANGE    = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   // One breakpoint: signed Q16.16 x, unsigned Q16.16 y.
   typedef struct packed {
      logic signed [31:0] x;
      logic        [31:0] y;
   } point_type;

   // Operands of the serial multiply-divide unit: quotient = a * b / d.
   typedef struct packed {
      logic [32:0] a_mag;
      logic [31:0] b_mag;
      logic [32:0] d_mag;
   } muldiv_req_type;

endpackage

/* hw/rtl/pli_cell.sv */
// One breakpoint cell of the rotating table chain.
module pli_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  pli_pkg::point_type  din,
   output pli_pkg::point_type  dout
);

   pli_pkg::point_type point_ff;

   // The cell takes its neighbor's point whenever the chain rotates.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         point_ff <= din;
      end
   end

   assign dout = point_ff;

endmodule

/* hw/rtl/pli_muldiv.sv */
// Serial shift-add multiplier followed by a restoring divider, one bit per cycle.
module pli_muldiv (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pli_pkg::muldiv_req_type  op,
   output logic                     done,
   output logic [31:0]              quot
);

   localparam int STEPS = 32;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [64:0] prod_ff, prod_in;
   logic [32:0] a_ff, a_in;
   logic [32:0] d_ff, d_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;

   logic [33:0] mul_sum;
   logic [64:0] prod_step;
   logic [33:0] trial;
   logic        ge;

   always_comb begin
      mul_sum   = {1'b0, prod_ff[64:32]} + (prod_ff[0] ? {1'b0, a_ff} : 34'd0);
      prod_step = {mul_sum, prod_ff[31:1]};
      trial     = {rem_ff, quo_ff[31]} - {1'b0, d_ff};
      ge        = !trial[33];

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      prod_in  = prod_ff;
      a_in     = a_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;

      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               prod_in  = {33'd0, op.b_mag};
               a_in     = op.a_mag;
               d_in     = op.d_mag;
               cnt_in   = 5'd0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            prod_in = prod_step;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(STEPS - 1)) begin
               // The quotient is known to fit 32 bits, so the upper half starts the remainder.
               rem_in   = {1'b0, prod_step[63:32]};
               quo_in   = prod_step[31:0];
               cnt_in   = 5'd0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            rem_in = ge ? trial[32:0] : {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(STEPS - 1)) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= 5'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

/* hw/rtl/piecewise_linear_interpolator_core.sv */
// Top level of the clamped piecewise linear interpolator.
//
// Requests arrive on the req_ channel (valid/stall). A write request
// (req_func = 0) stores one breakpoint in slot req_point_index; an evaluate
// request (req_func = 1) returns the curve's value at req_intensity. Every
// request produces exactly one response on the rsp_ channel (valid/stall)
// carrying rsp_damage and rsp_status. The csr_ channel writes num_points;
// csr_ready is always high and writes are expected only while idle.
// The table is a ring of MAX_POINTS cells that rotates one slot per cycle
// while a request scans it, so one request walks the whole ring. An empty
// table or an out-of-range write skips the scan; an interpolated evaluation
// then runs the bit-serial multiply and divide unit, while clamped
// evaluations do not. One request is worked on at a time; req_stall is high
// from acceptance until the result has been moved into the response
// register. A result waiting there does not block the next request, and
// while rsp_stall holds it, the response stays stable. Synchronous reset
// clears num_points, the response valid and the sequencer; table contents
// are undefined until written.
module piecewise_linear_interpolator_core #(
   parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [3:0]         req_point_index,
   input  logic signed [31:0] req_point_x,
   input  logic [31:0]        req_point_y,
   input  logic signed [31:0] req_intensity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_damage,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_num_points
);

   localparam int CW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_CALC   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   // Control registers.
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    num_points_ff;

   // Request and working registers.
   logic               func_ff, func_in;
   logic [3:0]         idx_ff, idx_in;
   pli_pkg::point_type wpt_ff, wpt_in;
   logic signed [31:0] ix_ff, ix_in;
   pli_pkg::point_type prev_ff, prev_in;
   pli_pkg::point_type first_ff, first_in;
   pli_pkg::point_type last_ff, last_in;
   pli_pkg::point_type seg0_ff, seg0_in;
   pli_pkg::point_type seg1_ff, seg1_in;
   logic [31:0]        y0_ff, y0_in;
   logic               neg_ff, neg_in;
   logic [31:0]        res_damage_ff, res_damage_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [31:0]        rsp_damage_ff, rsp_damage_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   // Cell ring.
   pli_pkg::point_type cell_in  [MAX_POINTS];
   pli_pkg::point_type cell_out [MAX_POINTS];
   pli_pkg::point_type head;
   pli_pkg::point_type feedback;
   logic               shift_en;
   logic               write_slot;

   // Multiply-divide unit.
   logic                    md_start;
   pli_pkg::muldiv_req_type md_op;
   logic                    md_done;
   logic [31:0]             md_quot;

   logic [NW-1:0]      n_eff;
   logic               req_accept;
   logic               rsp_load;
   logic               scan_last;
   logic signed [32:0] dx, dy, den;
   logic [33:0]        sum_sat;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_damage = rsp_damage_ff;
   assign rsp_status = rsp_status_ff;

   // Register values above the table size act as the table size.
   assign n_eff = (32'(num_points_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points_ff);

   // The ring rotates toward slot zero; the head cell holds table entry cnt_ff.
   assign head       = cell_out[0];
   assign shift_en   = (state_ff == S_SCAN);
   assign write_slot = !func_ff && (32'(cnt_ff) == 32'(idx_ff));
   assign feedback   = write_slot ? wpt_ff : head;
   assign scan_last  = (32'(cnt_ff) == MAX_POINTS - 1);

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      if (i == MAX_POINTS - 1) begin : g_tail
         assign cell_in[i] = feedback;
      end else begin : g_body
         assign cell_in[i] = cell_out[i+1];
      end
      pli_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .din      (cell_in[i]),
         .dout     (cell_out[i])
      );
   end

   always_comb begin
      dx  = {ix_ff[31], ix_ff} - {seg0_ff.x[31], seg0_ff.x};
      den = {seg1_ff.x[31], seg1_ff.x} - {seg0_ff.x[31], seg0_ff.x};
      dy  = {1'b0, seg1_ff.y} - {1'b0, seg0_ff.y};
      md_op.a_mag = dx[32]  ? 33'(-dx)  : 33'(dx);
      md_op.b_mag = dy[32]  ? 32'(-dy)  : dy[31:0];
      md_op.d_mag = den[32] ? 33'(-den) : 33'(den);
      sum_sat = {2'b00, y0_ff} + {2'b00, md_quot};
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      wpt_in        = wpt_ff;
      ix_in         = ix_ff;
      prev_in       = prev_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      seg0_in       = seg0_ff;
      seg1_in       = seg1_ff;
      y0_in         = y0_ff;
      neg_in        = neg_ff;
      res_damage_in = res_damage_ff;
      res_status_in = res_status_ff;
      md_start      = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in       = req_func;
               idx_in        = req_point_index;
               wpt_in.x      = req_point_x;
               wpt_in.y      = req_point_y;
               ix_in         = req_intensity;
               cnt_in        = '0;
               found_in      = 1'b0;
               res_damage_in = 32'd0;
               res_status_in = pli_pkg::STAT_OK;
               state_in      = S_SCAN;
               if (!req_func && (32'(req_point_index) >= MAX_POINTS)) begin
                  res_status_in = pli_pkg::STAT_RANGE;
                  state_in      = S_FINISH;
               end else if (req_func && (n_eff == '0)) begin
                  res_status_in = pli_pkg::STAT_EMPTY;
                  state_in      = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            prev_in = head;
            if (func_ff) begin
               if (cnt_ff == '0) begin
                  first_in = head;
               end
               if (32'(cnt_ff) + 1 == 32'(n_eff)) begin
                  last_in = head;
               end
               // First segment whose upper breakpoint is at or above the intensity.
               if ((cnt_ff != '0) && (32'(cnt_ff) < 32'(n_eff)) && !found_ff &&
                   (ix_ff <= head.x)) begin
                  found_in = 1'b1;
                  seg0_in  = prev_ff;
                  seg1_in  = head;
               end
            end else if (write_slot && (idx_ff != 4'd0) && (wpt_ff.x < prev_ff.x)) begin
               res_status_in = pli_pkg::STAT_UNSORTED;
            end
            cnt_in = cnt_ff + CW'(1);
            if (scan_last) begin
               cnt_in   = '0;
               state_in = func_ff ? S_DECIDE : S_FINISH;
            end
         end
         S_DECIDE: begin
            y0_in  = seg0_ff.y;
            neg_in = ((dx[32] != dy[32]) != den[32]) && (dx != '0) && (dy != '0);
            priority if (ix_ff <= first_ff.x) begin
               res_damage_in = first_ff.y;
               state_in      = S_FINISH;
            end else if ((ix_ff >= last_ff.x) || !found_ff) begin
               res_damage_in = last_ff.y;
               state_in      = S_FINISH;
            end else if (den == '0) begin
               res_damage_in = seg0_ff.y;
               state_in      = S_FINISH;
            end else begin
               md_start = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (md_done) begin
               if (neg_ff) begin
                  res_damage_in = (md_quot > y0_ff) ? 32'd0 : y0_ff - md_quot;
               end else begin
                  res_damage_in = sum_sat[32] ? 32'hFFFF_FFFF : sum_sat[31:0];
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Move the result out once the response register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_damage_in = rsp_load ? res_damage_ff : rsp_damage_ff;
      rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;
   end

   pli_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .op    (md_op),
      .done  (md_done),
      .quot  (md_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         num_points_ff <= 5'd0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            num_points_ff <= csr_num_points;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      wpt_ff        <= wpt_in;
      ix_ff         <= ix_in;
      prev_ff       <= prev_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      seg0_ff       <= seg0_in;
      seg1_ff       <= seg1_in;
      y0_ff         <= y0_in;
      neg_ff        <= neg_in;
      res_damage_ff <= res_damage_in;
      res_status_ff <= res_status_in;
      rsp_damage_ff <= rsp_damage_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

/* hw/rtl/pli_checker.sv */
// Port-level checks for the interpolator core and the bind that attaches them.
module pli_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_damage,
   input logic [1:0]  rsp_status
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_damage) && $stable(rsp_status))
      else $error("stalled response changed");

   // An accepted request makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a request without going busy");

   // Flagged write responses (unsorted or out of range) and empty-table responses carry zero damage.
   a_zero_damage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pli_pkg::STAT_UNSORTED ||
                    rsp_status == pli_pkg::STAT_RANGE ||
                    rsp_status == pli_pkg::STAT_EMPTY) |-> rsp_damage == 32'd0)
      else $error("nonzero damage on a write or empty-table response");

   // Reset leaves no response pending and the block ready.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or busy state survived reset");

endmodule

bind piecewise_linear_interpolator_core pli_checker u_pli_checker (.*);

/* tb/sv/piecewise_linear_interpolator_core_test.sv */
// Self-checking testbench for the piecewise linear interpolator core.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_core_test;

   localparam int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT;

   // Request function codes carried on req_func.
   localparam bit FUNC_WRITE = 1'b0;
   localparam bit FUNC_EVAL  = 1'b1;

   // Longest random gap the sender inserts before one request.
   localparam int MAX_SEND_GAP = 60;

   // Number of cycles the receiver holds off in the back-pressure test.
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [31:0] damage;
      logic [1:0]  status;
   } curve_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_func = FUNC_WRITE;
   logic [3:0]         req_point_index = '0;
   logic signed [31:0] req_point_x = '0;
   logic [31:0]        req_point_y = '0;
   logic signed [31:0] req_intensity = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_damage;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [4:0]         csr_num_points = '0;

   // Our own copy of the breakpoint table and of the num_points register.
   int          curve_x [MAX_POINTS];
   logic [31:0] curve_y [MAX_POINTS];
   logic [4:0]  points_in_use = '0;

   // Responses still owed by the block, oldest first.
   curve_result_type owed_results[$];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_left = 0;

   int error_count = 0;
   int n_writes = 0;
   int n_unsorted = 0;
   int n_evals = 0;
   int n_interp = 0;
   int n_clamped = 0;
   int n_empty = 0;

   piecewise_linear_interpolator_core #(
      .MAX_POINTS(MAX_POINTS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_point_index(req_point_index),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_intensity  (req_intensity),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_damage     (rsp_damage),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_num_points (csr_num_points)
   );

   always #1 clock = ~clock;

   // Safety net: a hung handshake ends the run here.
   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] expected_value,
                                  input logic [31:0] actual_value);
      $display("ERROR at %0t: %s, expected %h, got %h", $realtime, what, expected_value,
               actual_value);
      error_count++;
   endtask

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // Value on the straight line through (x0, y0) and (x1, y1) at x, with the
   // quotient truncated toward zero and the sum held to the 32-bit range.
   function automatic logic [31:0] interp_segment(input longint x, input longint x0,
                                                  input logic [31:0] y0, input longint x1,
                                                  input logic [31:0] y1);
      longint            dx;
      longint            den;
      longint            dy;
      longint unsigned   q;
      bit                neg;
      dx  = x - x0;
      den = x1 - x0;
      dy  = $signed({32'd0, y1}) - $signed({32'd0, y0});
      if (den == 0)
         return y0;
      q   = (magnitude(dx) * magnitude(dy)) / magnitude(den);
      neg = ((dx < 0) != (dy < 0)) != (den < 0);
      if (dx == 0 || dy == 0)
         neg = 1'b0;
      if (neg)
         return (q > {32'd0, y0}) ? 32'd0 : y0 - q[31:0];
      if (q > 64'hFFFF_FFFF - {32'd0, y0})
         return 32'hFFFF_FFFF;
      return y0 + q[31:0];
   endfunction

   // Applies one accepted request to the table copy and returns the response
   // the block owes for it.
   function automatic curve_result_type predict_response(input bit func, input logic [3:0] idx,
                                                         input int px, input logic [31:0] py,
                                                         input int inten);
      curve_result_type r;
      int               n;
      bit               found;
      r.damage = '0;
      r.status = pli_pkg::STAT_OK;
      if (func == FUNC_WRITE) begin
         n_writes++;
         if (idx >= MAX_POINTS) begin
            r.status = pli_pkg::STAT_RANGE;
         end else begin
            // An out-of-order point is still stored, only flagged.
            if (idx > 0 && px < curve_x[idx - 1]) begin
               r.status = pli_pkg::STAT_UNSORTED;
               n_unsorted++;
            end
            curve_x[idx] = px;
            curve_y[idx] = py;
         end
      end else begin
         n_evals++;
         n = (points_in_use > MAX_POINTS) ? MAX_POINTS : points_in_use;
         if (n == 0) begin
            r.status = pli_pkg::STAT_EMPTY;
            n_empty++;
         end else if (inten <= curve_x[0]) begin
            r.damage = curve_y[0];
            n_clamped++;
         end else if (inten >= curve_x[n - 1]) begin
            r.damage = curve_y[n - 1];
            n_clamped++;
         end else begin
            // Use the first breakpoint at or above the intensity.
            found    = 1'b0;
            r.damage = curve_y[n - 1];
            for (int i = 1; i < n && !found; i++) begin
               if (inten <= curve_x[i]) begin
                  r.damage = interp_segment(longint'(inten), longint'(curve_x[i - 1]),
                                            curve_y[i - 1], longint'(curve_x[i]), curve_y[i]);
                  found    = 1'b1;
                  n_interp++;
               end
            end
         end
      end
      return r;
   endfunction

   // Offers one request after a random gap and returns in the time step in
   // which it was accepted. req_valid is left high, so back-to-back requests
   // keep it high; the next caller either re-drives or lowers it.
   task automatic send_request(input bit func, input logic [3:0] idx, input int px,
                               input logic [31:0] py, input int inten);
      int gap;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_point_index <= idx;
      req_point_x     <= px;
      req_point_y     <= py;
      req_intensity   <= inten;
      do @(posedge clock); while (req_stall);
      owed_results.push_back(predict_response(func, idx, px, py, inten));
   endtask

   task automatic write_point(input logic [3:0] idx, input int px, input logic [31:0] py);
      send_request(FUNC_WRITE, idx, px, py, int'($urandom));
   endtask

   // Point fields carry random junk, since an evaluation ignores them.
   task automatic evaluate_at(input int inten);
      send_request(FUNC_EVAL, 4'($urandom), int'($urandom), $urandom, inten);
   endtask

   // Stops offering requests and waits until every owed response has come.
   // Every request produces a response, so the block is idle after that.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (owed_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Writes num_points; only called while the block is idle.
   task automatic program_num_points(input logic [4:0] value);
      csr_valid      <= 1'b1;
      csr_num_points <= value;
      do @(posedge clock); while (!csr_ready);
      points_in_use = value;
      csr_valid     <= 1'b0;
   endtask

   // Receiver: checks each accepted response against the oldest owed one and
   // picks the stall for the next cycle. A running hold-off forces a stall.
   always @(posedge clock) begin
      curve_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            report_mismatch("response with no request outstanding", 32'd0, rsp_damage);
         end else begin
            want = owed_results.pop_front();
            if (rsp_damage !== want.damage)
               report_mismatch("rsp_damage", want.damage, rsp_damage);
            if (rsp_status !== want.status)
               report_mismatch("rsp_status", 32'(want.status), 32'(rsp_status));
         end
      end
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
   end

   // Hold-off counter, started by the back-pressure test.
   always @(posedge clock) begin
      if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // Right after reset num_points is zero, so every evaluation must report an
   // empty table, whatever the intensity.
   task automatic test_empty_table();
      evaluate_at(32'sh8000_0000);
      evaluate_at(32'sh7FFF_FFFF);
      drain_responses();
   endtask

   // Hand-built curve: extreme x and y values, a descending segment, a wide
   // segment, a hit exactly on a breakpoint, equal x values, an out-of-order
   // point, a num_points above the table size and a single-point table.
   task automatic test_directed_curve();
      write_point(4'd0, 32'sh8000_0000, 32'h0000_0000);
      write_point(4'd1, -32'sd65536, 32'hFFFF_FFFF);
      write_point(4'd2, 32'sd0, 32'h8000_0000);
      write_point(4'd3, 32'sd0, 32'h0001_0000);
      write_point(4'd4, 32'sh0003_0000, 32'h5555_5555);
      drain_responses();
      program_num_points(5'd5);
      evaluate_at(32'sh8000_0000);     // at the first point, clamps low
      evaluate_at(32'sh7FFF_FFFF);     // past the last point, clamps high
      evaluate_at(-32'sd32768);        // falling segment
      evaluate_at(-32'sh4000_0000);    // segment spanning almost half the range
      evaluate_at(32'sd0);             // exactly on a breakpoint
      evaluate_at(32'sh0001_8000);     // segment starting after two equal x values
      // Slot 5 goes below slot 4 and must be flagged but kept.
      write_point(4'd5, -32'sd5, 32'hA5A5_5A5A);
      for (int i = 6; i < MAX_POINTS; i++)
         write_point(4'(i), i << 16, 32'(i) << 27);
      drain_responses();
      program_num_points(5'd31);
      evaluate_at(32'sh0007_8000);
      evaluate_at(32'sh0000_4000);
      drain_responses();
      program_num_points(5'd1);
      evaluate_at(32'sh8000_0001);
      evaluate_at(32'sh0000_0001);
      drain_responses();
   endtask

   // Random curves: set num_points, write a table that is mostly ascending,
   // then evaluate it at points that land inside segments, on breakpoints, at
   // the ends and anywhere at all. Some tables carry a swapped pair or a stray
   // write, and a few num_points settings are zero or above the table size.
   task automatic test_random_curves(input int item_budget);
      int              xs[$];
      int              sent;
      int              cfg;
      int              n;
      int              k;
      int              j;
      int              tmp;
      int              inten;
      int              pick;
      int              base;
      bit              narrow;
      bit              flat;
      logic [31:0]     flat_y;
      longint          lo;
      longint          hi;
      longint unsigned r;
      sent = 0;
      while (sent < item_budget) begin
         drain_responses();
         pick = $urandom_range(99);
         if (pick < 5)
            cfg = 0;
         else if (pick < 12)
            cfg = $urandom_range(31, 17);
         else
            cfg = $urandom_range(16, 1);
         program_num_points(5'(cfg));
         n = (cfg == 0) ? $urandom_range(16, 1) : ((cfg > MAX_POINTS) ? MAX_POINTS : cfg);

         // Narrow tables bunch the x values so that repeats and short
         // segments show up; flat ones give zero slope.
         narrow = ($urandom_range(3) == 0);
         flat   = ($urandom_range(9) == 0);
         flat_y = $urandom;
         base   = int'($urandom);
         xs.delete();
         for (int i = 0; i < n; i++)
            xs.push_back(narrow ? base + int'($urandom_range(4 * n)) : int'($urandom));
         xs.sort();
         if (n > 1 && $urandom_range(9) == 0) begin
            j         = $urandom_range(n - 2);
            tmp       = xs[j];
            xs[j]     = xs[j + 1];
            xs[j + 1] = tmp;
         end
         for (int i = 0; i < n; i++)
            write_point(4'(i), xs[i], flat ? flat_y : $urandom);
         sent += n;
         if ($urandom_range(4) == 0) begin
            write_point(4'($urandom), int'($urandom), $urandom);
            sent++;
         end

         k = $urandom_range(16, 6);
         for (int e = 0; e < k; e++) begin
            pick = $urandom_range(99);
            if (pick < 40 && n > 1) begin
               j     = $urandom_range(n - 1, 1);
               lo    = (xs[j - 1] < xs[j]) ? xs[j - 1] : xs[j];
               hi    = (xs[j - 1] < xs[j]) ? xs[j] : xs[j - 1];
               r     = {$urandom, $urandom};
               inten = int'(lo + longint'(r % (hi - lo + 1)));
            end else if (pick < 55) begin
               inten = xs[$urandom_range(n - 1)];
            end else if (pick < 70) begin
               inten = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end else begin
               inten = int'($urandom);
            end
            evaluate_at(inten);
         end
         sent += k;
      end
      drain_responses();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering back to back, so the response register and the sequencer both
   // fill and req_stall has to hold the sender.
   task automatic test_backpressure();
      int unsigned saved_idle;
      saved_idle      = sender_idle_pct;
      sender_idle_pct = 0;
      drain_responses();
      hold_left <= HOLD_OFF_CYCLES;
      for (int i = 0; i < 24; i++) begin
         if ($urandom_range(3) == 0)
            write_point(4'($urandom), int'($urandom), $urandom);
         else
            evaluate_at(int'($urandom));
      end
      drain_responses();
      sender_idle_pct = saved_idle;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_directed_curve();

      // Four mixes of sender gaps and receiver stalls, from none to heavy.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_random_curves(450);
      test_backpressure();

      sender_idle_pct    = 80;
      receiver_stall_pct = 0;
      test_random_curves(450);

      sender_idle_pct    = 0;
      receiver_stall_pct = 80;
      test_random_curves(450);

      sender_idle_pct    = 36;
      receiver_stall_pct = 36;
      test_random_curves(450);

      // Give a stray late response time to show up before the verdict.
      drain_responses();
      repeat (MAX_POINTS + 80) @(posedge clock);
      if (owed_results.size() != 0)
         report_mismatch("responses never delivered", 32'd0, 32'(owed_results.size()));

      $display("Covered %0d breakpoint writes (%0d out of order) and %0d evaluations:",
               n_writes, n_unsorted, n_evals);
      $display("  %0d interpolated, %0d clamped, %0d on an empty table, num_points 0 to 31.",
               n_interp, n_clamped, n_empty);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
